// File: src/mspi_pkg.sv
`timescale 1ns / 1ps

package mspi_pkg;

  localparam int GAIN_FRAC_BITS = 8;
  localparam int PERIOD_WIDTH   = 16;

  localparam int SET_W      = 8;
  localparam int GAIN_W     = 10;
  localparam int CPS_W      = 18;
  localparam int DUTY_W     = 8;
  localparam int SPEED_W    = 8;
  localparam int ERR_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam int PROD_W    = GAIN_W + 1 + ERR_W;
  localparam int ACC_BASE  = (DUTY_W + GAIN_FRAC_BITS > PROD_W) ?
                             DUTY_W + GAIN_FRAC_BITS : PROD_W;
  localparam int ACC_W     = ACC_BASE + 2;
  localparam int CMP_W     = (CPS_W > PERIOD_WIDTH + SPEED_W) ?
                             CPS_W : PERIOD_WIDTH + SPEED_W;
  localparam int DIV_CNT_W = $clog2(SPEED_W);
  localparam int PC_W      = 4;

  localparam logic [SET_W-1:0]  SETPOINT_RST = SET_W'(40);
  localparam logic [GAIN_W-1:0] KP_RST       = GAIN_W'(102);
  localparam logic [GAIN_W-1:0] KPKI_RST     = GAIN_W'(179);
  localparam logic [CPS_W-1:0]  CPS_RST      = CPS_W'(250000);
  localparam logic [DUTY_W-1:0] DUTY_MAX_RST = DUTY_W'(100);
  localparam logic [DUTY_W-1:0] DUTY_RST     = DUTY_W'(50);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT = 3'd0,
    CFG_KP       = 3'd1,
    CFG_KPKI     = 3'd2,
    CFG_CPS      = 3'd3,
    CFG_DUTY_MAX = 3'd4
  } cfg_idx_e;

  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_FETCH    = 4'd0;
  localparam pc_t PC_DIV_INIT = 4'd1;
  localparam pc_t PC_DIV_STEP = 4'd2;
  localparam pc_t PC_ERR      = 4'd3;
  localparam pc_t PC_MUL      = 4'd4;
  localparam pc_t PC_ADD      = 4'd5;
  localparam pc_t PC_SUB      = 4'd6;
  localparam pc_t PC_WAIT     = 4'd7;
  localparam pc_t PC_COMMIT   = 4'd8;

  typedef enum logic [2:0] {
    J_NEXT,
    J_WAIT_IN,
    J_SKIP_DIV,
    J_DIV_LOOP,
    J_WAIT_OUT,
    J_ALWAYS
  } jump_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_e;

  typedef enum logic {
    MUL_KPKI_ERR,
    MUL_KP_PREV
  } mul_sel_e;

  typedef struct packed {
    jump_e    jump;
    pc_t      target;
    logic     ld_in;
    logic     div_init;
    logic     div_step;
    logic     calc_err;
    logic     mul_en;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     commit;
  } ctrl_t;

  // microcode rom
  function automatic ctrl_t ucode(pc_t pc);
    ctrl_t w;
    w = '0;
    unique case (pc)
      PC_FETCH: begin
        w.jump   = J_WAIT_IN;
        w.target = PC_FETCH;
        w.ld_in  = 1'b1;
      end
      PC_DIV_INIT: begin
        w.jump     = J_SKIP_DIV;
        w.target   = PC_ERR;
        w.div_init = 1'b1;
      end
      PC_DIV_STEP: begin
        w.jump     = J_DIV_LOOP;
        w.target   = PC_DIV_STEP;
        w.div_step = 1'b1;
      end
      PC_ERR: begin
        w.calc_err = 1'b1;
        w.acc_op   = ACC_LOAD;
      end
      PC_MUL: begin
        w.mul_en  = 1'b1;
        w.mul_sel = MUL_KPKI_ERR;
      end
      PC_ADD: begin
        w.mul_en  = 1'b1;
        w.mul_sel = MUL_KP_PREV;
        w.acc_op  = ACC_ADD;
      end
      PC_SUB: begin
        w.acc_op = ACC_SUB;
      end
      PC_WAIT: begin
        w.jump   = J_WAIT_OUT;
        w.target = PC_WAIT;
      end
      PC_COMMIT: begin
        w.jump   = J_ALWAYS;
        w.target = PC_FETCH;
        w.commit = 1'b1;
      end
      default: begin
        w.jump   = J_ALWAYS;
        w.target = PC_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

// File: src/motor_speed_pi_controller.sv
`timescale 1ns / 1ps

// channel | direction | handshake                | payload
// --------+-----------+--------------------------+--------------------------------------------
// cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
// in      | in        | in_valid_i / in_ready_o   | period_count_i
// out     | out       | out_valid_o / out_ready_i | duty_cycle_o, measured_speed_o, speed_error_o
//
// after the input transaction the program runs the divider init step, the shift-subtract
// divider loop and the error, multiply, add, subtract, wait and commit steps, and the
// result is registered at commit; a zero period or a saturated speed skips the loop
// the next input is taken while the previous result waits in the output register
// a stalled output holds the program at its wait step before the commit
// reset restores the configuration defaults, duty 50 and previous error 0

module motor_speed_pi_controller import mspi_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [PERIOD_WIDTH-1:0] period_count_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [DUTY_W-1:0]       duty_cycle_o,
  output logic [SPEED_W-1:0]      measured_speed_o,
  output logic signed [ERR_W-1:0] speed_error_o
);

  logic [SET_W-1:0]  setpoint_q;
  logic [GAIN_W-1:0] kp_q;
  logic [GAIN_W-1:0] kpki_q;
  logic [CPS_W-1:0]  cps_q;
  logic [DUTY_W-1:0] duty_max_q;

  pc_t   pc_q, pc_d;
  ctrl_t ctrl;

  logic                    skip_q, skip_d;
  logic [PERIOD_WIDTH-1:0] period_q;
  logic [PERIOD_WIDTH-1:0] rem_q;
  logic [SPEED_W-1:0]      dvd_q;
  logic [DIV_CNT_W-1:0]    cnt_q;
  logic [SPEED_W-1:0]      speed_q;

  logic signed [ERR_W-1:0]  err_q, err_d;
  logic signed [ERR_W-1:0]  prev_q;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic [DUTY_W-1:0]        duty_q, duty_d;

  logic                     out_valid_q;
  logic [DUTY_W-1:0]        out_duty_q;
  logic [SPEED_W-1:0]       out_speed_q;
  logic signed [ERR_W-1:0]  out_err_q;

  logic                    in_fire;
  logic                    ovf;
  logic [PERIOD_WIDTH:0]   rem_sh;
  logic                    rem_ge;
  logic signed [SET_W:0]   diff;
  logic [GAIN_W-1:0]       mul_gain;
  logic signed [ERR_W-1:0] mul_err;
  logic signed [ACC_W-1:0] prod_ext;
  logic [ACC_W-GAIN_FRAC_BITS-1:0] whole;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (pc_q == PC_FETCH);
  assign in_fire     = in_valid_i && in_ready_o;
  assign ctrl        = ucode(pc_q);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q <= SETPOINT_RST;
      kp_q       <= KP_RST;
      kpki_q     <= KPKI_RST;
      cps_q      <= CPS_RST;
      duty_max_q <= DUTY_MAX_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SETPOINT: setpoint_q <= cfg_data_i[SET_W-1:0];
        CFG_KP:       kp_q       <= cfg_data_i[GAIN_W-1:0];
        CFG_KPKI:     kpki_q     <= cfg_data_i[GAIN_W-1:0];
        CFG_CPS:      cps_q      <= cfg_data_i[CPS_W-1:0];
        CFG_DUTY_MAX: duty_max_q <= cfg_data_i[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    unique case (ctrl.jump)
      J_NEXT:     pc_d = pc_q + 1'b1;
      J_WAIT_IN:  pc_d = in_valid_i ? pc_q + 1'b1 : ctrl.target;
      J_SKIP_DIV: pc_d = skip_q ? ctrl.target : pc_q + 1'b1;
      J_DIV_LOOP: pc_d = (cnt_q != DIV_CNT_W'(SPEED_W - 1)) ? ctrl.target : pc_q + 1'b1;
      J_WAIT_OUT: pc_d = (out_valid_q && !out_ready_i) ? ctrl.target : pc_q + 1'b1;
      J_ALWAYS:   pc_d = ctrl.target;
      default:    pc_d = PC_FETCH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

  // speed saturation check and divider step
  assign ovf    = CMP_W'(cps_q) >= (CMP_W'(period_count_i) << SPEED_W);
  assign skip_d = (period_count_i == '0) || ovf;
  assign rem_sh = {rem_q, dvd_q[SPEED_W-1]};
  assign rem_ge = rem_sh >= {1'b0, period_q};

  always_ff @(posedge clk_i) begin
    if (ctrl.ld_in && in_fire) begin
      period_q <= period_count_i;
      skip_q   <= skip_d;
      speed_q  <= (period_count_i == '0) ? '0 : '1;
    end
    if (ctrl.div_init) begin
      rem_q <= PERIOD_WIDTH'(cps_q >> SPEED_W);
      dvd_q <= cps_q[SPEED_W-1:0];
      cnt_q <= '0;
    end
    if (ctrl.div_step) begin
      rem_q   <= rem_ge ? PERIOD_WIDTH'(rem_sh - {1'b0, period_q}) : rem_sh[PERIOD_WIDTH-1:0];
      dvd_q   <= {dvd_q[SPEED_W-2:0], 1'b0};
      cnt_q   <= cnt_q + 1'b1;
      speed_q <= {speed_q[SPEED_W-2:0], rem_ge};
    end
  end

  // error, multiply and accumulate
  assign diff = $signed({1'b0, setpoint_q}) - $signed({1'b0, speed_q});

  always_comb begin
    if (diff > $signed((SET_W+1)'(127))) begin
      err_d = ERR_W'(127);
    end else if (diff < -$signed((SET_W+1)'(128))) begin
      err_d = -ERR_W'(128);
    end else begin
      err_d = diff[ERR_W-1:0];
    end
  end

  assign mul_gain = (ctrl.mul_sel == MUL_KP_PREV) ? kp_q : kpki_q;
  assign mul_err  = (ctrl.mul_sel == MUL_KP_PREV) ? prev_q : err_q;
  assign prod_d   = PROD_W'($signed({1'b0, mul_gain})) * PROD_W'(mul_err);
  assign prod_ext = ACC_W'(prod_q);

  always_comb begin
    case (ctrl.acc_op)
      ACC_LOAD: acc_d = $signed(ACC_W'(duty_q) << GAIN_FRAC_BITS);
      ACC_ADD:  acc_d = acc_q + prod_ext;
      ACC_SUB:  acc_d = acc_q - prod_ext;
      default:  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.calc_err) begin
      err_q <= err_d;
    end
    if (ctrl.mul_en) begin
      prod_q <= prod_d;
    end
    acc_q <= acc_d;
  end

  // clamp of the new duty
  assign whole = acc_q[ACC_W-1:GAIN_FRAC_BITS];

  always_comb begin
    if (acc_q[ACC_W-1] || acc_q == '0) begin
      duty_d = '0;
    end else if (whole > (ACC_W-GAIN_FRAC_BITS)'(duty_max_q)) begin
      duty_d = duty_max_q;
    end else begin
      duty_d = whole[DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q <= DUTY_RST;
      prev_q <= '0;
    end else if (ctrl.commit) begin
      duty_q <= duty_d;
      prev_q <= err_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.commit) begin
      out_duty_q  <= duty_d;
      out_speed_q <= speed_q;
      out_err_q   <= err_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign duty_cycle_o     = out_duty_q;
  assign measured_speed_o = out_speed_q;
  assign speed_error_o    = out_err_q;

endmodule
